### rtl/core/vga_pma_pkg.sv
package vga_pma_pkg;

	// Video memory geometry
	localparam int unsigned PLANE_WORDS = 65536;
	localparam int unsigned IDX_W       = $clog2(PLANE_WORDS);

	// Configuration register indexes
	localparam logic [2:0] REG_WRITE_CONTROL   = 3'd0;
	localparam logic [2:0] REG_SET_RESET       = 3'd1;
	localparam logic [2:0] REG_BIT_MASK        = 3'd2;
	localparam logic [2:0] REG_MAP_MASK        = 3'd3;
	localparam logic [2:0] REG_READ_MAP_SELECT = 3'd4;
	localparam logic [2:0] REG_COLOR_COMPARE   = 3'd5;
	localparam logic [2:0] REG_ADDRESSING      = 3'd6;

	// Access codes
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// Logic op codes
	localparam logic [1:0] LOP_NONE = 2'd0;
	localparam logic [1:0] LOP_AND  = 2'd1;
	localparam logic [1:0] LOP_OR   = 2'd2;
	localparam logic [1:0] LOP_XOR  = 2'd3;

	// Write mode codes
	localparam logic [1:0] WM_ROTATE = 2'd0;
	localparam logic [1:0] WM_LATCH  = 2'd1;
	localparam logic [1:0] WM_FILL   = 2'd2;
	localparam logic [1:0] WM_SETRES = 2'd3;

	typedef logic [IDX_W-1:0] word_idx_t;

	// Spread one bit per plane over the plane's byte lane
	function automatic logic [31:0] fill4(input logic [3:0] n);
		return {{8{n[3]}}, {8{n[2]}}, {8{n[1]}}, {8{n[0]}}};
	endfunction

	// Copy one byte to all four planes
	function automatic logic [31:0] expand8(input logic [7:0] v);
		return {4{v}};
	endfunction

	// Rotate a byte right
	function automatic logic [7:0] rot8(input logic [7:0] v, input logic [2:0] n);
		logic [15:0] w;
		w = {v, v} >> n;
		return w[7:0];
	endfunction

	// Fold a CPU address into a plane word index
	function automatic word_idx_t word_index(input logic [15:0] pa, input logic [5:0] adr);
		logic [31:0] hi;
		logic [31:0] top;
		logic [31:0] m;
		logic [31:0] idx;
		logic        hbit;
		hi   = adr[3] ? 32'd0 : ~32'h0000_FFFF;
		top  = adr[1] ? (32'd1 << 16) : (32'd1 << 14);
		hbit = adr[1] ? 1'b0 : pa[14];
		if (adr[2] && !adr[5]) begin
			m   = hi + top - 32'd2;
			idx = ({16'd0, pa} & m & (PLANE_WORDS - 1)) + {31'd0, hbit};
		end else begin
			m   = hi + top - 32'd1;
			idx = {16'd0, pa} & m & (PLANE_WORDS - 1);
		end
		if (idx >= PLANE_WORDS) begin
			idx = idx - PLANE_WORDS;
		end
		return idx[IDX_W-1:0];
	endfunction

endpackage

### rtl/core/vga_planar_memory_access.sv
// Planar video memory front end of a VGA graphics controller.
// Command port: start/op/addr/write_data are taken at a rising edge where
// start is high and busy is low. A read gives one result on read_data,
// marked by valid for exactly one cycle; a write gives no result.
// Configuration port: cfg_wr_en/cfg_index/cfg_wr_data write one register
// at the rising edge where cfg_wr_en is high; indexes past the list are
// dropped. Write registers only while the block is idle.
// Timing: the accepted access reads its plane word from video memory into
// a register as it is taken, then does the merge and write-back (or latch
// load) in the access stage; busy stays high while that stage runs, so a
// new access cannot be taken before the last one is done; the
// read-modify-write of the memory word sets this. A read result is
// registered into read_data and valid after the access stage. The receiver
// cannot stall; results are never held.
// Reset: registers take their reset values at once, and a clearing pass
// then zeroes video memory one word a cycle, all PLANE_WORDS (65536)
// words, during which busy is high and no access is taken. Config writes
// are taken during the pass.
module vga_planar_memory_access (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic       op,
	input  logic [15:0] addr,
	input  logic [7:0] write_data,
	output logic       valid,
	output logic [7:0] read_data,
	input  logic       cfg_wr_en,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_wr_data
);
	import vga_pma_pkg::*;

	// Configuration registers
	logic [7:0] write_control_q;
	logic [7:0] set_reset_q;
	logic [7:0] bit_mask_q;
	logic [3:0] map_mask_q;
	logic [1:0] read_map_select_q;
	logic [7:0] color_compare_q;
	logic [5:0] addressing_q;

	// Control
	logic      clearing_q;
	word_idx_t clr_cnt_q;
	logic      active_q;
	logic      accept;

	// Access stage
	logic       op_s1;
	logic [15:0] addr_s1;
	logic [7:0] wdata_s1;
	word_idx_t  idx_s1;

	// Memory
	logic [31:0] vram [PLANE_WORDS];
	logic [31:0] rd_s1;
	logic        mem_we;
	word_idx_t   mem_waddr;
	logic [31:0] mem_wdata;
	word_idx_t   rd_idx;

	logic [31:0] latch_q;
	logic [7:0]  read_q;
	logic        valid_q;

	// Datapath
	logic        chained;
	logic        oddeven;
	logic [15:0] pa;
	logic [1:0]  plane;
	logic [31:0] cmp_t;
	logic [7:0]  rd_byte;
	logic [3:0]  plane_en;
	logic [31:0] wmask;
	logic [31:0] bm;
	logic [31:0] rot_full;
	logic [31:0] lop_in;
	logic [31:0] lop_m;
	logic [31:0] lop_out;
	logic [31:0] alu_out;
	logic [3:0]  sr_en;
	logic [3:0]  sr_val;

	assign accept = start && !busy;
	assign busy   = clearing_q || active_q;
	assign valid  = valid_q;
	assign read_data = read_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_control_q   <= 8'h00;
			set_reset_q       <= 8'h00;
			bit_mask_q        <= 8'hFF;
			map_mask_q        <= 4'hF;
			read_map_select_q <= 2'd0;
			color_compare_q   <= 8'h00;
			addressing_q      <= 6'd0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_WRITE_CONTROL:   write_control_q   <= cfg_wr_data;
				REG_SET_RESET:       set_reset_q       <= cfg_wr_data;
				REG_BIT_MASK:        bit_mask_q        <= cfg_wr_data;
				REG_MAP_MASK:        map_mask_q        <= cfg_wr_data[3:0];
				REG_READ_MAP_SELECT: read_map_select_q <= cfg_wr_data[1:0];
				REG_COLOR_COMPARE:   color_compare_q   <= cfg_wr_data;
				REG_ADDRESSING:      addressing_q      <= cfg_wr_data[5:0];
				default: ;
			endcase
		end
	end

	// Fold the incoming address into a word index
	assign chained = addressing_q[4];
	assign oddeven = !addressing_q[0] && !addressing_q[5];
	assign pa      = chained ? {addr[15:2], 2'b00} : addr;
	assign rd_idx  = word_index(pa, addressing_q);

	// Sweep the memory clear after reset, then track the access in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
			active_q   <= 1'b0;
			valid_q    <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == word_idx_t'(PLANE_WORDS - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			active_q <= accept;
			valid_q  <= active_q && (op_s1 == OP_READ);
		end
	end

	// Hold the accepted access
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= op;
			addr_s1  <= addr;
			wdata_s1 <= write_data;
			idx_s1   <= rd_idx;
		end
	end

	// Video memory: one write port, one registered read port
	always_comb begin
		if (clearing_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_cnt_q;
			mem_wdata = '0;
		end else begin
			mem_we    = active_q && (op_s1 == OP_WRITE);
			mem_waddr = idx_s1;
			mem_wdata = (rd_s1 & ~wmask) | (alu_out & wmask);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			vram[mem_waddr] <= mem_wdata;
		end
		rd_s1 <= vram[rd_idx];
	end

	// Read path: plane byte or color compare on the fetched word
	always_comb begin
		plane = chained ? addr_s1[1:0] : read_map_select_q;
		if (oddeven) begin
			plane = {plane[1], addr_s1[0]};
		end
		cmp_t = (rd_s1 & fill4(color_compare_q[7:4]))
			^ fill4(color_compare_q[3:0] & color_compare_q[7:4]);
		if (write_control_q[7]) begin
			rd_byte = ~(cmp_t[7:0] | cmp_t[15:8] | cmp_t[23:16] | cmp_t[31:24]);
		end else begin
			case (plane)
				2'd0:    rd_byte = rd_s1[7:0];
				2'd1:    rd_byte = rd_s1[15:8];
				2'd2:    rd_byte = rd_s1[23:16];
				default: rd_byte = rd_s1[31:24];
			endcase
		end
	end

	// Load the latch and the result on a read transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q <= '0;
		end else if (active_q && (op_s1 == OP_READ)) begin
			latch_q <= rd_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (active_q && (op_s1 == OP_READ)) begin
			read_q <= rd_byte;
		end
	end

	// Plane write mask
	always_comb begin
		plane_en = map_mask_q;
		if (oddeven) begin
			plane_en = plane_en & (addr_s1[0] ? 4'b1010 : 4'b0101);
		end else if (chained) begin
			plane_en = plane_en & (4'b0001 << addr_s1[1:0]);
		end
		wmask = fill4(plane_en);
	end

	// Write ALU: mode select, then logic op against the latch (latch mode writes the latch as is)
	always_comb begin
		bm       = expand8(bit_mask_q);
		sr_en    = set_reset_q[7:4];
		sr_val   = set_reset_q[3:0];
		rot_full = expand8(rot8(wdata_s1, write_control_q[6:4]));
		case (write_control_q[1:0])
			WM_ROTATE: begin
				lop_in = (rot_full & ~fill4(sr_en)) | fill4(sr_en & sr_val);
				lop_m  = bm;
			end
			WM_FILL: begin
				lop_in = fill4(wdata_s1[3:0]);
				lop_m  = bm;
			end
			WM_SETRES: begin
				lop_in = fill4(sr_val);
				lop_m  = rot_full & bm;
			end
			default: begin
				lop_in = latch_q;
				lop_m  = bm;
			end
		endcase
		case (write_control_q[3:2])
			LOP_NONE: lop_out = (lop_in & lop_m) | (latch_q & ~lop_m);
			LOP_AND:  lop_out = (lop_in | ~lop_m) & latch_q;
			LOP_OR:   lop_out = (lop_in & lop_m) | latch_q;
			default:  lop_out = (lop_in & lop_m) ^ latch_q;
		endcase
		alu_out = (write_control_q[1:0] == WM_LATCH) ? latch_q : lop_out;
	end

endmodule
